/* rtl/stbs_pkg.sv */
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 1;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

    // Result code for an absent target (-1 in two's complement)
    localparam logic signed [CNT_W-1:0] NOT_FOUND = '1;

    // Depth as a count-width value
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [CNT_W-1:0]  result_t;

endpackage

/* rtl/stbs_in_if.sv */
interface stbs_in_if;

    logic                           valid;
    logic                           ready;
    logic [stbs_pkg::FUNC_W-1:0]    func;
    stbs_pkg::addr_t                index;
    stbs_pkg::data_t                value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink   (input valid, input func, input index, input value, output ready);

endinterface

/* rtl/stbs_out_if.sv */
interface stbs_out_if;

    logic               valid;
    logic               ready;
    stbs_pkg::result_t  found_index;

    modport source (output valid, output found_index, input ready);
    modport sink   (input valid, input found_index, output ready);

endinterface

/* rtl/sorted_table_binary_search_unit.sv */
// Operation: a write item is stored to the table on acceptance; a search registers the
//   target and reads the middle entry, narrows the interval one probe at a time (at most
//   11 probes over 1024 entries), and loads the result register once it is free.
// Occupancy: one item at a time; a search also waits for the result register to drain.
// Reset: rst_n clears the control state, the result valid flag and count_reg; the table
//   contents are undefined until written, and no clearing pass is run.
module sorted_table_binary_search_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  stbs_pkg::cnt_t       cfg_wdata,
    stbs_in_if.sink              req,
    stbs_out_if.source           rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]         state_reg, state_next;
    stbs_pkg::cnt_t     count_reg;
    stbs_pkg::cnt_t     lo_reg, lo_next;
    stbs_pkg::cnt_t     end_reg, end_next;
    stbs_pkg::addr_t    mid_reg, mid_next;
    stbs_pkg::data_t    target_reg, target_next;
    stbs_pkg::result_t  result_reg, result_next;
    logic               rsp_valid_reg, rsp_valid_next;
    stbs_pkg::result_t  found_reg, found_next;

    stbs_pkg::data_t    table_mem [stbs_pkg::TABLE_DEPTH];
    stbs_pkg::data_t    rd_data_reg;
    logic               rd_en;
    stbs_pkg::addr_t    rd_addr;
    logic               wr_en;

    stbs_pkg::cnt_t     n_clamp;
    stbs_pkg::cnt_t     first_span;
    stbs_pkg::cnt_t     probe_lo, probe_end, probe_span;
    logic               accept;
    logic               out_free;

    // Clamp the searched count to the table depth
    assign n_clamp    = (count_reg > stbs_pkg::DEPTH_CNT) ? stbs_pkg::DEPTH_CNT : count_reg;
    assign first_span = n_clamp - stbs_pkg::CNT_W'(1);

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign wr_en      = accept && (req.func == stbs_pkg::FUNC_WRITE);

    // Narrow the interval from the probed entry
    always_comb
    begin
        probe_lo  = lo_reg;
        probe_end = end_reg;
        if (target_reg < rd_data_reg)
        begin
            probe_end = {1'b0, mid_reg};
        end
        else
        begin
            probe_lo = {1'b0, mid_reg} + stbs_pkg::CNT_W'(1);
        end
        probe_span = probe_end - probe_lo - stbs_pkg::CNT_W'(1);
    end

    // Sequence the search
    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        end_next    = end_reg;
        mid_next    = mid_reg;
        target_next = target_reg;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = mid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.func == stbs_pkg::FUNC_SEARCH))
                begin
                    target_next = req.value;
                    lo_next     = '0;
                    end_next    = n_clamp;
                    if (n_clamp == '0)
                    begin
                        result_next = stbs_pkg::NOT_FOUND;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        mid_next   = first_span[stbs_pkg::ADDR_W:1];
                        rd_en      = 1'b1;
                        rd_addr    = first_span[stbs_pkg::ADDR_W:1];
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (target_reg == rd_data_reg)
                begin
                    result_next = stbs_pkg::result_t'(mid_reg);
                    state_next  = ST_RESULT;
                end
                else if (probe_lo >= probe_end)
                begin
                    result_next = stbs_pkg::NOT_FOUND;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    lo_next  = probe_lo;
                    end_next = probe_end;
                    mid_next = stbs_pkg::ADDR_W'(probe_lo + (probe_span >> 1));
                    rd_en    = 1'b1;
                    rd_addr  = stbs_pkg::ADDR_W'(probe_lo + (probe_span >> 1));
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load the result register, drop it on transfer
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        found_next     = found_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            rsp_valid_next = 1'b1;
            found_next     = result_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        end_reg    <= end_next;
        mid_reg    <= mid_next;
        target_reg <= target_next;
        result_reg <= result_next;
        found_reg  <= found_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[req.index] <= req.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found_index = found_reg;

    // Checks
    a_probe_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (lo_reg < end_reg))
        else $error("probe with empty interval");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (({1'b0, mid_reg} >= lo_reg) && ({1'b0, mid_reg} < end_reg)))
        else $error("probe index outside interval");

    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (end_reg <= n_clamp))
        else $error("interval end beyond entry count");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((found_reg == stbs_pkg::NOT_FOUND)
                           || (stbs_pkg::cnt_t'(found_reg) < n_clamp)))
        else $error("found index beyond entry count");

    a_no_read_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en) && !((state_reg != ST_IDLE) && wr_en))
        else $error("table write during search");

endmodule
